FILE: rtl/bac_pkg.sv
package bac_pkg;

   // Number of byte values tracked by the map.
   localparam int ALPHABET = 256;

   localparam int BYTE_W     = 8;
   localparam int RANK_W     = 9;
   localparam int SEG_IDX_W  = 3;
   localparam int SEG_W      = 1 << SEG_IDX_W;
   localparam int SEG_CNT_W  = SEG_IDX_W + 1;
   localparam int CELL_IDX_W = BYTE_W - SEG_IDX_W;
   localparam int NCELL      = (ALPHABET + SEG_W - 1) / SEG_W;

   localparam logic [1:0] KIND_LEARN  = 2'd0;
   localparam logic [1:0] KIND_ENCODE = 2'd1;
   localparam logic [1:0] KIND_DECODE = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   localparam logic [BYTE_W-1:0] UNKNOWN_CHAR = 8'd63;

   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] symbol;
      logic              unknown;
      logic [RANK_W-1:0] distinct_count;
   } rsp_type;

   // Request travelling down the row of cells.
   typedef struct packed {
      logic              vld;
      logic [1:0]        kind;
      logic [BYTE_W-1:0] value;
      logic [RANK_W-1:0] rank;   // seen bytes in the cells already passed
      logic              found;
      logic [BYTE_W-1:0] sym;
   } token_type;

endpackage

FILE: rtl/bac_cell.sv
module bac_cell import bac_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [CELL_IDX_W-1:0] cell_idx,
   input  token_type             tok_i,
   output token_type             tok_o
);

   logic [SEG_W-1:0]     seg_ff;
   logic [SEG_W-1:0]     seg_in;
   logic [SEG_W-1:0]     live_mask;
   logic                 hit;
   logic [SEG_IDX_W-1:0] bit_sel;
   logic [SEG_CNT_W-1:0] seg_cnt;
   logic [SEG_CNT_W-1:0] below_cnt;
   logic [SEG_CNT_W-1:0] pick_cnt;
   logic [SEG_IDX_W-1:0] pick_idx;
   logic                 pick_ok;
   logic [RANK_W-1:0]    rank_top;
   logic [RANK_W-1:0]    target;
   token_type            tok_in;
   token_type            tok_ff;

   assign hit     = tok_i.value[BYTE_W-1:SEG_IDX_W] == cell_idx;
   assign bit_sel = tok_i.value[SEG_IDX_W-1:0];

   // Bits whose byte lies inside the alphabet.
   always_comb begin
      for (int j = 0; j < SEG_W; j++) begin
         live_mask[j] = {1'b0, cell_idx, SEG_IDX_W'(j)} < RANK_W'(ALPHABET);
      end
   end

   always_comb begin
      seg_in = seg_ff;
      if (tok_i.vld) begin
         case (tok_i.kind)
            KIND_LEARN: begin
               if (hit) begin
                  seg_in[bit_sel] = seg_ff[bit_sel] | live_mask[bit_sel];
               end
            end
            KIND_CLEAR: seg_in = '0;
            default: seg_in = seg_ff;
         endcase
      end
   end

   always_comb begin
      seg_cnt   = '0;
      below_cnt = '0;
      for (int j = 0; j < SEG_W; j++) begin
         seg_cnt = seg_cnt + SEG_CNT_W'(seg_in[j]);
         if (SEG_IDX_W'(j) < bit_sel) begin
            below_cnt = below_cnt + SEG_CNT_W'(seg_ff[j]);
         end
      end
   end

   assign rank_top = tok_i.rank + RANK_W'(seg_cnt);
   assign target   = RANK_W'(tok_i.value) - tok_i.rank;

   // Select the set bit whose local rank matches the target.
   always_comb begin
      pick_ok  = 1'b0;
      pick_idx = '0;
      pick_cnt = '0;
      for (int j = 0; j < SEG_W; j++) begin
         if (seg_ff[j] && !pick_ok) begin
            if (pick_cnt == target[SEG_CNT_W-1:0]) begin
               pick_ok  = 1'b1;
               pick_idx = SEG_IDX_W'(j);
            end
            pick_cnt = pick_cnt + SEG_CNT_W'(1);
         end
      end
   end

   always_comb begin
      tok_in      = tok_i;
      tok_in.rank = rank_top;
      case (tok_i.kind)
         KIND_ENCODE: begin
            if (hit && seg_ff[bit_sel] && !tok_i.found) begin
               tok_in.sym   = BYTE_W'(tok_i.rank + RANK_W'(below_cnt));
               tok_in.found = 1'b1;
            end
         end
         KIND_DECODE: begin
            if (!tok_i.found && pick_ok && RANK_W'(tok_i.value) < rank_top) begin
               tok_in.sym   = {cell_idx, pick_idx};
               tok_in.found = 1'b1;
            end
         end
         default: tok_in.sym = tok_i.sym;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
         tok_ff <= '0;
      end else if (advance) begin
         seg_ff <= seg_in;
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

FILE: rtl/byte_alphabet_compactor_core.sv
// Channel   Direction  Payload    Handshake
// req_      in         req_type   req_valid / req_ready
// rsp_      out        rsp_type   rsp_valid / rsp_ready
//
// Takes one request per cycle while the response is not stalled; each request walks
// the row of cells, one cell a cycle while the row advances, and its response comes
// from the last of the NCELL cells, one cell per eight map bits.
// Reset clears the whole map and empties the row.
// A stalled response holds every cell; requests are then refused.
module byte_alphabet_compactor_core import bac_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   token_type chain [NCELL+1];
   logic      advance;

   // Advance the whole row unless the last cell holds an untaken response.
   assign advance   = !chain[NCELL].vld || rsp_ready;
   assign req_ready = advance;

   // Fresh token: nothing counted, nothing found.
   always_comb begin
      chain[0]       = '0;
      chain[0].vld   = req_valid;
      chain[0].kind  = req_data.kind;
      chain[0].value = req_data.value;
   end

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      bac_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (CELL_IDX_W'(i)),
         .tok_i    (chain[i]),
         .tok_o    (chain[i+1])
      );
   end

   // Shape the response from the token leaving the last cell.
   always_comb begin
      rsp_valid               = chain[NCELL].vld;
      rsp_data.distinct_count = chain[NCELL].rank;
      case (chain[NCELL].kind)
         KIND_ENCODE: begin
            rsp_data.symbol  = chain[NCELL].found ? chain[NCELL].sym : '0;
            rsp_data.unknown = !chain[NCELL].found;
         end
         KIND_DECODE: begin
            rsp_data.symbol  = chain[NCELL].found ? chain[NCELL].sym : UNKNOWN_CHAR;
            rsp_data.unknown = !chain[NCELL].found;
         end
         default: begin
            rsp_data.symbol  = '0;
            rsp_data.unknown = 1'b0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.distinct_count <= RANK_W'(ALPHABET))
      else $error("distinct count beyond alphabet");

   a_unknown_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.unknown) |->
         (rsp_data.symbol == '0 || rsp_data.symbol == UNKNOWN_CHAR))
      else $error("unknown response with unexpected symbol");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response present straight after reset");

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !(rsp_valid && !rsp_ready))
      else $error("request taken while row stalled");
`endif

endmodule
